>>> src/i2c_master_bit_engine_macros.svh
// Assertion macros for the I2C master bit engine checker.
// Depends on nothing; the including module provides clk and rst_n.
`ifndef I2C_MASTER_BIT_ENGINE_MACROS_SVH
`define I2C_MASTER_BIT_ENGINE_MACROS_SVH

// Check a property on every clock edge outside reset
`define I2CBE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define I2CBE_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/i2cbe_pkg.sv
// Shared types, codes and constants of the I2C master bit engine.
// Used by the front, queue, back and top-level modules.
package i2cbe_pkg;

  localparam int I2CBE_QUEUE_DEPTH = 2;
  localparam int TPU_W   = 10;
  localparam int WAIT_W  = 13;
  localparam int PHASE_W = 6;
  localparam int US_W    = 3;

  // last phase of the bit loop of send byte, and bit phases of read byte
  localparam logic [PHASE_W-1:0] SEND_LAST_BIT_PHASE = 6'd24;
  localparam logic [PHASE_W-1:0] READ_BIT_PHASES     = 6'd24;
  localparam logic [1:0]         SUB_LAST            = 2'd2;

  // phase waits in microseconds
  localparam logic [US_W-1:0] US_NONE = 3'd0;
  localparam logic [US_W-1:0] US_1    = 3'd1;
  localparam logic [US_W-1:0] US_2    = 3'd2;
  localparam logic [US_W-1:0] US_3    = 3'd3;
  localparam logic [US_W-1:0] US_4    = 3'd4;
  localparam logic [US_W-1:0] US_5    = 3'd5;

  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_START    = 3'd1,
    OP_RESTART  = 3'd2,
    OP_STOP     = 3'd3,
    OP_SEND     = 3'd4,
    OP_READ     = 3'd5,
    OP_READ_ACK = 3'd6,
    OP_SEND_ACK = 3'd7
  } op_t;

  typedef enum logic [7:0] {
    CMD_IDLE     = 8'b0000_0001,
    CMD_START    = 8'b0000_0010,
    CMD_RESTART  = 8'b0000_0100,
    CMD_STOP     = 8'b0000_1000,
    CMD_SEND     = 8'b0001_0000,
    CMD_READ     = 8'b0010_0000,
    CMD_READ_ACK = 8'b0100_0000,
    CMD_SEND_ACK = 8'b1000_0000
  } cmd_state_t;

  // classified input word
  typedef struct packed {
    cmd_state_t  kind;
    logic [7:0]  data_byte;
    logic        ack_to_send;
    logic        sda_in;
  } item_t;

  // result word
  typedef struct packed {
    logic        rejected;
    logic        nack_seen;
    logic [7:0]  read_data;
    logic        done_res;
    logic        busy_res;
    logic        sda_level;
    logic        scl_level;
  } res_t;

  function automatic cmd_state_t op_to_cmd(input op_t op);
    cmd_state_t c;
    case (op)
      OP_START:    c = CMD_START;
      OP_RESTART:  c = CMD_RESTART;
      OP_STOP:     c = CMD_STOP;
      OP_SEND:     c = CMD_SEND;
      OP_READ:     c = CMD_READ;
      OP_READ_ACK: c = CMD_READ_ACK;
      OP_SEND_ACK: c = CMD_SEND_ACK;
      default:     c = CMD_IDLE;
    endcase
    return c;
  endfunction

endpackage

>>> src/i2cbe_front.sv
// Front stage: accepts input words and classifies the operation code.
// Depends on i2cbe_pkg; feeds i2cbe_queue.
module i2cbe_front import i2cbe_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_op,
  input  logic [7:0]  in_data_byte,
  input  logic        in_ack_to_send,
  input  logic        in_sda_in,
  output logic        q_valid,
  input  logic        q_ready,
  output item_t       q_item
);

  logic  valid_r;
  item_t item_r;

  // take a word when empty or when the held one moves on
  assign in_ready = !valid_r || q_ready;
  assign q_valid  = valid_r;
  assign q_item   = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (q_ready) begin
      valid_r <= 1'b0;
    end
  end

  // classify and hold the payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.kind        <= op_to_cmd(op_t'(in_op));
      item_r.data_byte   <= in_data_byte;
      item_r.ack_to_send <= in_ack_to_send;
      item_r.sda_in      <= in_sda_in;
    end
  end

endmodule

>>> src/i2cbe_queue.sv
// Short queue of classified words between the front and back stages.
// Depends on i2cbe_pkg for the word type.
module i2cbe_queue import i2cbe_pkg::*; #(
  parameter int DEPTH = I2CBE_QUEUE_DEPTH
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  out_valid,
  input  logic  out_ready,
  output item_t out_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  item_t            mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             push;
  logic             pop;

  assign in_ready  = (count_r != CNT_FULL);
  assign out_valid = (count_r != '0);
  assign out_item  = mem_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  // store the word
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_item;
    end
  end

endmodule

>>> src/i2cbe_back.sv
// Back stage: runs the command phase sequencer one word per cycle while the
// result word is not stalled, and holds the result word. Depends on i2cbe_pkg.
module i2cbe_back import i2cbe_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [TPU_W-1:0] ticks_per_us,
  input  logic             q_valid,
  output logic             q_ready,
  input  item_t            q_item,
  output logic             out_valid,
  input  logic             out_ready,
  output res_t             out_res
);

  cmd_state_t         cmd_r, cmd_nxt;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [1:0]         sub_r, sub_nxt;
  logic [WAIT_W-1:0]  wait_r, wait_nxt;
  logic [7:0]         shift_r, shift_nxt;
  logic               scl_r, scl_nxt;
  logic               sda_r, sda_nxt;
  logic               ack_flag_r, ack_flag_nxt;
  logic [7:0]         held_read_r, held_read_nxt;
  logic               held_ack_r, held_ack_nxt;
  logic               out_valid_r;
  res_t               out_res_r;

  logic               take;
  logic               enter;
  logic               done;
  logic               rej;
  logic [US_W-1:0]    us;
  logic [WAIT_W-1:0]  wait_dec;
  logic [TPU_W-1:0]   tpu_eff;

  assign take      = q_valid && (!out_valid_r || out_ready);
  assign q_ready   = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign tpu_eff   = (ticks_per_us == '0) ? TPU_W'(1) : ticks_per_us;
  assign wait_dec  = wait_r - WAIT_W'(wait_r != '0);

  // step the sequencer for one word
  always_comb begin
    cmd_nxt       = cmd_r;
    phase_nxt     = phase_r;
    sub_nxt       = sub_r;
    wait_nxt      = wait_r;
    shift_nxt     = shift_r;
    scl_nxt       = scl_r;
    sda_nxt       = sda_r;
    ack_flag_nxt  = ack_flag_r;
    held_read_nxt = held_read_r;
    held_ack_nxt  = held_ack_r;
    enter         = 1'b0;
    done          = 1'b0;
    rej           = 1'b0;
    us            = US_NONE;

    // start a command when idle, else count down the phase wait
    if (cmd_r == CMD_IDLE) begin
      if (q_item.kind != CMD_IDLE) begin
        cmd_nxt   = q_item.kind;
        phase_nxt = '0;
        sub_nxt   = (q_item.kind == CMD_SEND) ? SUB_LAST : 2'd0;
        if (q_item.kind == CMD_SEND) shift_nxt = q_item.data_byte;
        if (q_item.kind == CMD_READ) shift_nxt = 8'h00;
        if (q_item.kind == CMD_SEND_ACK) held_ack_nxt = q_item.ack_to_send;
        enter = 1'b1;
      end
    end else begin
      rej      = (q_item.kind != CMD_IDLE);
      wait_nxt = wait_dec;
      if (wait_dec == '0) begin
        phase_nxt = phase_r + PHASE_W'(1);
        sub_nxt   = (sub_r == SUB_LAST) ? 2'd0 : sub_r + 2'd1;
        enter     = 1'b1;
      end
    end

    // apply the actions of the phase being entered
    if (enter) begin
      case (cmd_nxt)
        CMD_START: begin
          if (phase_nxt == 6'd0) begin
            sda_nxt = 1'b0; scl_nxt = 1'b1; us = US_5;
          end else if (phase_nxt == 6'd1) begin
            scl_nxt = 1'b0; us = US_5;
          end
        end
        CMD_RESTART: begin
          if (phase_nxt == 6'd0) begin
            scl_nxt = 1'b0; sda_nxt = 1'b1; us = US_5;
          end else if (phase_nxt == 6'd1) begin
            scl_nxt = 1'b1; us = US_5;
          end else if (phase_nxt == 6'd2) begin
            sda_nxt = 1'b0; us = US_5;
          end
        end
        CMD_STOP: begin
          if (phase_nxt == 6'd0) begin
            sda_nxt = 1'b0; scl_nxt = 1'b1; us = US_5;
          end else if (phase_nxt == 6'd1) begin
            sda_nxt = 1'b1; us = US_5;
          end
        end
        CMD_SEND: begin
          if (phase_nxt == 6'd0) begin
            scl_nxt = 1'b0; us = US_3;
          end else if (phase_nxt <= SEND_LAST_BIT_PHASE) begin
            if (sub_nxt == 2'd0) begin
              sda_nxt   = shift_r[7];
              shift_nxt = {shift_r[6:0], 1'b0};
              us        = US_3;
            end else if (sub_nxt == 2'd1) begin
              scl_nxt = 1'b1; us = US_4;
            end else begin
              scl_nxt = 1'b0; us = US_2;
            end
          end else begin
            sda_nxt = 1'b1;
          end
        end
        CMD_READ: begin
          if (phase_nxt < READ_BIT_PHASES) begin
            if (sub_nxt == 2'd0) begin
              scl_nxt = 1'b0; sda_nxt = 1'b1; us = US_3;
            end else if (sub_nxt == 2'd1) begin
              scl_nxt = 1'b1; us = US_2;
            end else begin
              shift_nxt = {shift_nxt[6:0], q_item.sda_in};
              us        = US_1;
            end
          end else begin
            scl_nxt       = 1'b0;
            held_read_nxt = shift_nxt;
          end
        end
        CMD_READ_ACK: begin
          if (phase_nxt == 6'd0) begin
            sda_nxt = 1'b1; scl_nxt = 1'b0; us = US_3;
          end else if (phase_nxt == 6'd1) begin
            scl_nxt = 1'b1; us = US_3;
          end else if (phase_nxt == 6'd2) begin
            ack_flag_nxt = q_item.sda_in; scl_nxt = 1'b0; us = US_3;
          end
        end
        CMD_SEND_ACK: begin
          if (phase_nxt == 6'd0) begin
            scl_nxt = 1'b0; us = US_3;
          end else if (phase_nxt == 6'd1) begin
            sda_nxt = !held_ack_nxt; us = US_3;
          end else if (phase_nxt == 6'd2) begin
            scl_nxt = 1'b1; us = US_3;
          end else if (phase_nxt == 6'd3) begin
            scl_nxt = 1'b0; us = US_1;
          end
        end
        default: us = US_NONE;
      endcase

      // finish the command or load the scaled wait
      if (us == US_NONE) begin
        cmd_nxt   = CMD_IDLE;
        phase_nxt = '0;
        wait_nxt  = '0;
        done      = 1'b1;
      end else begin
        wait_nxt = WAIT_W'({{(WAIT_W-US_W){1'b0}}, us} *
                           {{(WAIT_W-TPU_W){1'b0}}, tpu_eff});
      end
    end
  end

  // commit sequencer state on each taken word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r       <= CMD_IDLE;
      phase_r     <= '0;
      sub_r       <= 2'd0;
      wait_r      <= '0;
      shift_r     <= 8'h00;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      ack_flag_r  <= 1'b0;
      held_read_r <= 8'h00;
      held_ack_r  <= 1'b0;
    end else if (take) begin
      cmd_r       <= cmd_nxt;
      phase_r     <= phase_nxt;
      sub_r       <= sub_nxt;
      wait_r      <= wait_nxt;
      shift_r     <= shift_nxt;
      scl_r       <= scl_nxt;
      sda_r       <= sda_nxt;
      ack_flag_r  <= ack_flag_nxt;
      held_read_r <= held_read_nxt;
      held_ack_r  <= held_ack_nxt;
    end
  end

  // hold the result word until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_res_r.scl_level <= scl_nxt;
      out_res_r.sda_level <= sda_nxt;
      out_res_r.busy_res  <= (cmd_nxt != CMD_IDLE);
      out_res_r.done_res  <= done;
      out_res_r.read_data <= held_read_nxt;
      out_res_r.nack_seen <= ack_flag_nxt;
      out_res_r.rejected  <= rej;
    end
  end

endmodule

>>> src/i2c_master_bit_engine.sv
// I2C master bit engine: one result word for every input word, at a sustained
// rate of one word per clock cycle when the result side does not stall. A word
// passes a classifying input register, a short queue and the phase sequencer,
// whose result register holds the result; either side may stall on its own while
// the queue absorbs the difference. Each word is one tick: the sequencer counts
// down the current phase wait (microseconds times ticks_per_us) and enters the
// next phase when it runs out. ticks_per_us is written over the APB port at
// byte address 0; the user must write it only while the engine is idle (unchecked).
// Depends on i2cbe_pkg, i2cbe_front, i2cbe_queue and i2cbe_back.
module i2c_master_bit_engine import i2cbe_pkg::*; #(
  parameter int QUEUE_DEPTH = I2CBE_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // data_byte[7:0], ack_to_send[8], sda_in[9], zero[15:10]
  input  logic [2:0]  in_tuser,    // operation[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // scl_level[0], sda_level[1], busy_res[2], done_res[3],
                                   // read_data[11:4], nack_seen[12], rejected[13], zero[15:14]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [TPU_W-1:0] tpu_r;
  logic             cfg_sel_tpu;
  logic             f_valid;
  logic             f_ready;
  item_t            f_item;
  logic             b_valid;
  logic             b_ready;
  item_t            b_item;
  res_t             res;

  // configuration register
  assign cfg_pready  = 1'b1;
  assign cfg_sel_tpu = (cfg_paddr[2] == 1'b0);
  assign cfg_prdata  = cfg_sel_tpu ? {{(32-TPU_W){1'b0}}, tpu_r} : 32'h0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpu_r <= TPU_W'(1);
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_sel_tpu) begin
      tpu_r <= cfg_pwdata[TPU_W-1:0];
    end
  end

  i2cbe_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_tvalid),
    .in_ready       (in_tready),
    .in_op          (in_tuser),
    .in_data_byte   (in_tdata[7:0]),
    .in_ack_to_send (in_tdata[8]),
    .in_sda_in      (in_tdata[9]),
    .q_valid        (f_valid),
    .q_ready        (f_ready),
    .q_item         (f_item)
  );

  i2cbe_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_item   (f_item),
    .out_valid (b_valid),
    .out_ready (b_ready),
    .out_item  (b_item)
  );

  i2cbe_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .ticks_per_us (tpu_r),
    .q_valid      (b_valid),
    .q_ready      (b_ready),
    .q_item       (b_item),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_res      (res)
  );

  // pack the result word
  assign out_tdata = {2'b00, res.rejected, res.nack_seen, res.read_data, res.done_res,
                      res.busy_res, res.sda_level, res.scl_level};

endmodule

>>> src/i2cbe_checker.sv
// Port-level checks of the I2C master bit engine, bound to the top level.
// Depends on i2c_master_bit_engine_macros.svh.
`include "i2c_master_bit_engine_macros.svh"

module i2cbe_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // a stalled result word holds
  `I2CBE_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "result word changed while stalled")

  // a finished command leaves the engine idle
  `I2CBE_ASSERT(a_done_idle, out_tvalid && out_tdata[3] |-> !out_tdata[2], "done reported while busy")

  // a rejected command on an idle result only happens on the finishing word
  `I2CBE_ASSERT(a_rej_done, out_tvalid && out_tdata[13] && !out_tdata[2] |-> out_tdata[3], "rejection without running command")

  // reset empties the result register
  `I2CBE_ASSERT_RST(a_rst_empty, !rst_n |=> !out_tvalid, "result word valid after reset")

endmodule

bind i2c_master_bit_engine i2cbe_checker u_chk (.*);

>>> tb/i2c_master_bit_engine_tb.sv
// Self-checking bench for the I2C master bit engine: a tick-level model of the
// phase sequencer predicts every result word and the monitor checks each field.
// Depends on i2cbe_pkg and i2c_master_bit_engine.
module i2c_master_bit_engine_tb import i2cbe_pkg::*;;

  localparam logic [2:0] TPU_ADDR = 3'd0;
  localparam int CYCLE_LIMIT     = 2_000_000;
  localparam int PRESSURE_CYCLES = 300;

  typedef enum int {SDA_RANDOM, SDA_LOW, SDA_RELEASED} sda_mode_t;

  // one input word as the line sequencer sees it
  typedef struct {
    op_t        op;
    logic [7:0] data_byte;
    logic       ack_to_send;
    logic       sda_in;
  } bus_word_t;

  // sequencer state, timing register included
  typedef struct {
    logic [9:0]  tpu;
    op_t         cmd;
    logic [5:0]  step;
    logic [12:0] wait_left;
    logic [7:0]  shreg;
    logic        scl;
    logic        sda;
    logic        ack_flag;
    logic [7:0]  held_read;
    logic        held_ack;
  } seq_model_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // data_byte[7:0], ack_to_send[8], sda_in[9], zero[15:10]
  logic [2:0]  in_tuser = '0;   // operation[2:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // scl[0], sda[1], busy[2], done[3], read_data[11:4],
                                // nack_seen[12], rejected[13], zero[15:14]
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  seq_model_t  plan_model;
  seq_model_t  line_model;
  bus_word_t   pending_words[$];
  res_t        expected_levels[$];
  int          planned_words = 0;
  int          result_count = 0;
  int          error_count = 0;
  int          cycle_count = 0;
  int          send_gap = 0;
  int          ready_hold = 0;
  logic        pressure_done = 1'b0;
  logic        calm = 1'b0;

  i2c_master_bit_engine i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #5 clk = ~clk;

  function automatic seq_model_t fresh_model();
    seq_model_t m;
    m.tpu       = 10'd1;
    m.cmd       = OP_TICK;
    m.step      = '0;
    m.wait_left = '0;
    m.shreg     = '0;
    m.scl       = 1'b1;
    m.sda       = 1'b1;
    m.ack_flag  = 1'b0;
    m.held_read = '0;
    m.held_ack  = 1'b0;
    return m;
  endfunction

  // apply the drives of the current phase and return its wait in microseconds
  function automatic logic [US_W-1:0] apply_phase(inout seq_model_t m, input logic sda_now);
    logic [US_W-1:0] us;
    logic [5:0]      k;
    us = US_NONE;
    case (m.cmd)
      OP_START: begin
        if (m.step == 6'd0) begin
          m.sda = 1'b0; m.scl = 1'b1; us = US_5;
        end else if (m.step == 6'd1) begin
          m.scl = 1'b0; us = US_5;
        end
      end
      OP_RESTART: begin
        if (m.step == 6'd0) begin
          m.scl = 1'b0; m.sda = 1'b1; us = US_5;
        end else if (m.step == 6'd1) begin
          m.scl = 1'b1; us = US_5;
        end else if (m.step == 6'd2) begin
          m.sda = 1'b0; us = US_5;
        end
      end
      OP_STOP: begin
        if (m.step == 6'd0) begin
          m.sda = 1'b0; m.scl = 1'b1; us = US_5;
        end else if (m.step == 6'd1) begin
          m.sda = 1'b1; us = US_5;
        end
      end
      OP_SEND: begin
        if (m.step == 6'd0) begin
          m.scl = 1'b0; us = US_3;
        end else if (m.step <= SEND_LAST_BIT_PHASE) begin
          k = m.step - 6'd1;
          case (k % 6'd3)
            6'd0: begin
              m.sda = m.shreg[7]; m.shreg = {m.shreg[6:0], 1'b0}; us = US_3;
            end
            6'd1: begin
              m.scl = 1'b1; us = US_4;
            end
            default: begin
              m.scl = 1'b0; us = US_2;
            end
          endcase
        end else begin
          m.sda = 1'b1;
        end
      end
      OP_READ: begin
        if (m.step < READ_BIT_PHASES) begin
          case (m.step % 6'd3)
            6'd0: begin
              m.scl = 1'b0; m.sda = 1'b1; us = US_3;
            end
            6'd1: begin
              m.scl = 1'b1; us = US_2;
            end
            default: begin
              m.shreg = {m.shreg[6:0], sda_now}; us = US_1;
            end
          endcase
        end else begin
          m.scl = 1'b0; m.held_read = m.shreg;
        end
      end
      OP_READ_ACK: begin
        if (m.step == 6'd0) begin
          m.sda = 1'b1; m.scl = 1'b0; us = US_3;
        end else if (m.step == 6'd1) begin
          m.scl = 1'b1; us = US_3;
        end else if (m.step == 6'd2) begin
          m.ack_flag = sda_now; m.scl = 1'b0; us = US_3;
        end
      end
      OP_SEND_ACK: begin
        if (m.step == 6'd0) begin
          m.scl = 1'b0; us = US_3;
        end else if (m.step == 6'd1) begin
          m.sda = !m.held_ack; us = US_3;
        end else if (m.step == 6'd2) begin
          m.scl = 1'b1; us = US_3;
        end else if (m.step == 6'd3) begin
          m.scl = 1'b0; us = US_1;
        end
      end
      default: ;
    endcase
    return us;
  endfunction

  // enter the current phase; report whether the command just finished
  function automatic logic enter_phase(inout seq_model_t m, input logic sda_now);
    logic [US_W-1:0] us;
    logic [9:0]      tpu_eff;
    us = apply_phase(m, sda_now);
    tpu_eff = (m.tpu == '0) ? 10'd1 : m.tpu;
    if (us == US_NONE) begin
      m.cmd = OP_TICK;
      m.step = '0;
      m.wait_left = '0;
      return 1'b1;
    end
    m.wait_left = 13'(13'(us) * 13'(tpu_eff));
    return 1'b0;
  endfunction

  // advance the sequencer by one tick word and form its result word
  function automatic res_t advance_sequencer(inout seq_model_t m, input bus_word_t w);
    res_t r;
    logic done;
    logic rej;
    done = 1'b0;
    rej = 1'b0;
    if (m.cmd == OP_TICK) begin
      if (w.op != OP_TICK) begin
        m.cmd = w.op;
        m.step = '0;
        if (w.op == OP_SEND) m.shreg = w.data_byte;
        if (w.op == OP_READ) m.shreg = '0;
        if (w.op == OP_SEND_ACK) m.held_ack = w.ack_to_send;
        done = enter_phase(m, w.sda_in);
      end
    end else begin
      rej = (w.op != OP_TICK);
      if (m.wait_left != '0) m.wait_left = m.wait_left - 13'd1;
      if (m.wait_left == '0) begin
        m.step = m.step + 6'd1;
        done = enter_phase(m, w.sda_in);
      end
    end
    r.scl_level = m.scl;
    r.sda_level = m.sda;
    r.busy_res  = (m.cmd != OP_TICK);
    r.done_res  = done;
    r.read_data = m.held_read;
    r.nack_seen = m.ack_flag;
    r.rejected  = rej;
    return r;
  endfunction

  // mostly back to back, some short pauses, a few long ones
  function automatic int pick_gap();
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic pick_sda(input sda_mode_t mode);
    case (mode)
      SDA_LOW:      return 1'b0;
      SDA_RELEASED: return 1'b1;
      default:      return 1'($urandom_range(0, 1));
    endcase
  endfunction

  task automatic plan_word(input op_t op, input logic [7:0] data, input logic ack,
                           input logic sda);
    bus_word_t w;
    w.op = op;
    w.data_byte = data;
    w.ack_to_send = ack;
    w.sda_in = sda;
    void'(advance_sequencer(plan_model, w));
    pending_words.push_back(w);
    planned_words++;
  endtask

  // tick until the running command finishes; a few stray commands get rejected
  task automatic plan_until_idle(input sda_mode_t mode);
    while (plan_model.cmd != OP_TICK) begin
      if ($urandom_range(0, 11) == 0)
        plan_word(op_t'($urandom_range(1, 7)), 8'($urandom), 1'($urandom), pick_sda(mode));
      else
        plan_word(OP_TICK, 8'($urandom), 1'($urandom), pick_sda(mode));
    end
  endtask

  task automatic plan_command(input op_t op, input logic [7:0] data, input logic ack,
                              input sda_mode_t mode);
    plan_word(op, data, ack, pick_sda(mode));
    plan_until_idle(mode);
  endtask

  task automatic plan_random(input int n_words);
    int        first;
    sda_mode_t mode;
    first = planned_words;
    while (planned_words - first < n_words) begin
      if ($urandom_range(0, 7) == 0) begin
        plan_word(OP_TICK, 8'($urandom), 1'($urandom), 1'($urandom));
      end else begin
        case ($urandom_range(0, 3))
          0:       mode = SDA_LOW;
          1:       mode = SDA_RELEASED;
          default: mode = SDA_RANDOM;
        endcase
        plan_command(op_t'($urandom_range(1, 7)), 8'($urandom), 1'($urandom), mode);
      end
    end
  endtask

  // hold until every planned word has gone in and every result has come back
  task automatic wait_quiet();
    while (pending_words.size() != 0 || expected_levels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_tpu(input logic [9:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= TPU_ADDR;
    cfg_pwdata  <= 32'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    line_model.tpu = value;
    plan_model.tpu = value;
  endtask

  task automatic random_phase(input logic [9:0] tpu, input int n_words);
    write_tpu(tpu);
    plan_random(n_words);
    wait_quiet();
  endtask

  task automatic compare_field(input string name_str, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h actual %0h", $time, name_str, want, got);
      error_count++;
    end
  endtask

  // cycle count, calm stretches and the run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count % 256 == 0) calm <= ($urandom_range(0, 3) == 0);
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // driver: offer pending words, predict each one as it is taken
  always @(posedge clk) begin : drive_words
    bus_word_t w;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        w = pending_words.pop_front();
        expected_levels.push_back(advance_sequencer(line_model, w));
        send_gap = pick_gap();
      end
      if (in_tvalid && !in_tready) begin
        // hold the offered word
      end else if (send_gap != 0) begin
        send_gap--;
        in_tvalid <= 1'b0;
      end else if (pending_words.size() != 0) begin
        w = pending_words[0];
        in_tvalid <= 1'b1;
        in_tuser  <= w.op;
        in_tdata  <= {6'b0, w.sda_in, w.ack_to_send, w.data_byte};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // monitor: check each result word against the oldest prediction
  always @(posedge clk) begin : check_words
    res_t want;
    res_t got;
    if (!rst_n) begin
      out_tready <= 1'b0;
      ready_hold = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = res_t'(out_tdata[13:0]);
        if (expected_levels.size() == 0) begin
          $display("%0t: result word %h arrived with nothing expected", $time, out_tdata);
          error_count++;
        end else begin
          want = expected_levels.pop_front();
          compare_field("scl_level", 8'(want.scl_level), 8'(got.scl_level));
          compare_field("sda_level", 8'(want.sda_level), 8'(got.sda_level));
          compare_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
          compare_field("done_res", 8'(want.done_res), 8'(got.done_res));
          compare_field("read_data", want.read_data, got.read_data);
          compare_field("nack_seen", 8'(want.nack_seen), 8'(got.nack_seen));
          compare_field("rejected", 8'(want.rejected), 8'(got.rejected));
          compare_field("padding", 8'd0, 8'(out_tdata[15:14]));
        end
        result_count++;
      end
      // stall the result side once for long enough to back up the input
      if (!pressure_done && result_count >= 60 && pending_words.size() > 50) begin
        pressure_done = 1'b1;
        ready_hold = PRESSURE_CYCLES;
      end
      if (ready_hold != 0) begin
        ready_hold--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        ready_hold = pick_gap();
      end
    end
  end

  initial begin
    plan_model = fresh_model();
    line_model = fresh_model();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed words at the reset rate of one tick per microsecond
    plan_word(OP_TICK, 8'hFF, 1'b1, 1'b1);
    plan_word(OP_START, 8'h00, 1'b0, 1'b0);
    plan_word(OP_SEND_ACK, 8'hFF, 1'b1, 1'b1);
    plan_until_idle(SDA_RANDOM);
    plan_command(OP_SEND, 8'hA5, 1'b0, SDA_RANDOM);
    plan_command(OP_READ_ACK, 8'h00, 1'b0, SDA_LOW);
    plan_command(OP_READ, 8'h00, 1'b0, SDA_RELEASED);
    plan_command(OP_READ_ACK, 8'h00, 1'b0, SDA_RELEASED);
    plan_command(OP_SEND_ACK, 8'h00, 1'b1, SDA_RANDOM);
    plan_command(OP_SEND_ACK, 8'h00, 1'b0, SDA_RANDOM);
    plan_command(OP_RESTART, 8'h00, 1'b0, SDA_RANDOM);
    plan_command(OP_STOP, 8'h00, 1'b0, SDA_RANDOM);
    plan_word(OP_TICK, 8'h00, 1'b0, 1'b0);
    wait_quiet();

    // random traffic over several tick rates, zero among them
    random_phase(10'd2, 60);
    random_phase(10'd0, 50);
    random_phase(10'd3, 40);

    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+src
src/i2cbe_pkg.sv
src/i2cbe_front.sv
src/i2cbe_queue.sv
src/i2cbe_back.sv
src/i2c_master_bit_engine.sv
src/i2cbe_checker.sv
tb/i2c_master_bit_engine_tb.sv
